@@ src/twlc_pkg.sv @@
// Shared constants, item types and command types for the two-way LRU write-back cache.
`default_nettype none
package twlc_pkg;

	localparam int SET_COUNT   = 32;
	localparam int OFFSET_BITS = 4;
	localparam int ADDR_BITS   = 20;
	localparam int SET_BITS    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;

	localparam int HIT_LAT_W = 8;
	localparam int MISS_LAT_W = 8;
	localparam int MEM_LAT_W = 10;
	localparam int COST_W    = 12;
	localparam int CNT_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [HIT_LAT_W-1:0]  HIT_LAT_RESET  = 8'd6;
	localparam logic [MISS_LAT_W-1:0] MISS_LAT_RESET = 8'd4;
	localparam logic [MEM_LAT_W-1:0]  MEM_LAT_RESET  = 10'd100;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HIT_LATENCY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS_LATENCY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LATENCY = 2'd2;

	// access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic                 func;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              way;
		logic              wrote_back;
		logic [COST_W-1:0] cost_ticks;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  access_count;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch item, read tag memories
		logic update;   // compare, update set state, register result
	} cmd_t;

endpackage
`default_nettype wire

@@ src/twlc_ctrl.sv @@
// Controller state machine: sequences capture and lookup of one access.
`default_nettype none
module twlc_ctrl
	import twlc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output cmd_t      cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_LOOKUP;
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = start && (state_q == ST_IDLE);
	assign cmd.update  = (state_q == ST_LOOKUP);

endmodule
`default_nettype wire

@@ src/twlc_datapath.sv @@
// Datapath: tag memories, valid/dirty/LRU bits, latency registers, counters, result register.
`default_nettype none
module twlc_datapath
	import twlc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire req_t                  req,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       done,
	output rsp_t                       rsp
);

	logic [TAG_BITS-1:0] tag0_mem [SET_COUNT];
	logic [TAG_BITS-1:0] tag1_mem [SET_COUNT];

	logic [SET_COUNT-1:0] valid0_q, valid1_q, dirty0_q, dirty1_q, replace_q;

	logic [HIT_LAT_W-1:0]  hit_lat_q;
	logic [MISS_LAT_W-1:0] miss_lat_q;
	logic [MEM_LAT_W-1:0]  mem_lat_q;

	logic [CNT_W-1:0] hits_q, accesses_q;

	logic                func_q;
	logic [SET_BITS-1:0] set_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [TAG_BITS-1:0] rd0_q, rd1_q;

	rsp_t rsp_q;
	logic done_q;

	logic [SET_BITS-1:0] set_in;
	logic [TAG_BITS-1:0] tag_in;
	logic                hit0, hit1, hit, way_d, victim_dirty;
	logic [COST_W-1:0]   mem12, cost_d;
	logic [CNT_W-1:0]    acc_next, hits_next;

	assign set_in = req.address[OFFSET_BITS +: SET_BITS];
	assign tag_in = req.address[OFFSET_BITS + SET_BITS +: TAG_BITS];

	// invalid lines never match, so an unwritten tag word is harmless
	assign hit0  = valid0_q[set_q] && (rd0_q == tag_q);
	assign hit1  = valid1_q[set_q] && (rd1_q == tag_q);
	assign hit   = hit0 || hit1;
	assign way_d = hit0 ? 1'b0 : (hit1 ? 1'b1 : replace_q[set_q]);

	assign victim_dirty = !hit && (way_d ? (valid1_q[set_q] && dirty1_q[set_q])
	                                      : (valid0_q[set_q] && dirty0_q[set_q]));

	assign mem12  = {{(COST_W-MEM_LAT_W){1'b0}}, mem_lat_q};
	assign cost_d = hit ? {{(COST_W-HIT_LAT_W){1'b0}}, hit_lat_q}
	                    : ({{(COST_W-MISS_LAT_W){1'b0}}, miss_lat_q} + mem12
	                       + (victim_dirty ? mem12 : {COST_W{1'b0}}));

	assign acc_next  = (accesses_q == {CNT_W{1'b1}}) ? accesses_q : accesses_q + 1'b1;
	assign hits_next = (hit && (hits_q != {CNT_W{1'b1}})) ? hits_q + 1'b1 : hits_q;

	// tag memories: registered read at capture, write on a miss fill
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd0_q  <= tag0_mem[set_in];
			rd1_q  <= tag1_mem[set_in];
			func_q <= req.func;
			set_q  <= set_in;
			tag_q  <= tag_in;
		end
		if (cmd.update && !hit) begin
			if (way_d) tag1_mem[set_q] <= tag_q;
			else       tag0_mem[set_q] <= tag_q;
		end
		if (cmd.update) begin
			rsp_q.hit          <= hit;
			rsp_q.way          <= way_d;
			rsp_q.wrote_back   <= victim_dirty;
			rsp_q.cost_ticks   <= cost_d;
			rsp_q.hit_count    <= hits_next;
			rsp_q.access_count <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q   <= '0;
			valid1_q   <= '0;
			dirty0_q   <= '0;
			dirty1_q   <= '0;
			replace_q  <= '0;
			hits_q     <= '0;
			accesses_q <= '0;
			done_q     <= 1'b0;
			hit_lat_q  <= HIT_LAT_RESET;
			miss_lat_q <= MISS_LAT_RESET;
			mem_lat_q  <= MEM_LAT_RESET;
		end else begin
			done_q <= cmd.update;
			if (cfg_we) begin
				case (cfg_index)
					CFG_HIT_LATENCY:    hit_lat_q  <= cfg_data[HIT_LAT_W-1:0];
					CFG_MISS_LATENCY:   miss_lat_q <= cfg_data[MISS_LAT_W-1:0];
					CFG_MEMORY_LATENCY: mem_lat_q  <= cfg_data[MEM_LAT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.update) begin
				accesses_q       <= acc_next;
				hits_q           <= hits_next;
				replace_q[set_q] <= ~way_d;
				if (!hit) begin
					if (way_d) valid1_q[set_q] <= 1'b1;
					else       valid0_q[set_q] <= 1'b1;
				end
				if (func_q == FUNC_WRITE) begin
					if (way_d) dirty1_q[set_q] <= 1'b1;
					else       dirty0_q[set_q] <= 1'b1;
				end else if (!hit) begin
					if (way_d) dirty1_q[set_q] <= 1'b0;
					else       dirty0_q[set_q] <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

@@ src/two_way_lru_writeback_cache.sv @@
// Top level of the two-way set-associative LRU write-back cache tag and policy block.
`default_nettype none
// Each access is started by raising start while busy is low; the item (func, address)
// is taken at that edge, which also does the registered read of both tag memories at
// the set index. In the cycle that follows, busy is high while the tags are
// compared, the valid, dirty and LRU bits are updated, the victim tag is filled on a
// miss and the result is registered. The result then sits on rsp with done high for
// exactly one cycle; it cannot be held off, so sample it when done is high. busy is
// already low in that cycle, so a new access can be started there; the block takes no
// new access while one is in its tag-memory read or compare/update step. All lines
// start invalid after reset and way 0 is replaced first. The latency registers (index
// 0 hit, 1 miss, 2 memory) are written through cfg_valid/cfg_ready, always ready;
// write them only while the block is idle. Writes to other indexes are dropped.
module two_way_lru_writeback_cache
	import twlc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// access channel
	input  wire logic                  start,
	output logic                       busy,
	input  wire req_t                  req,
	// result channel
	output logic                       done,
	output rsp_t                       rsp,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	twlc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	twlc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.rsp       (rsp)
	);

	// an accepted item always moves into lookup
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not enter lookup");

	// a result only follows a lookup cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a lookup");

	// write-back only on a miss
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.wrote_back) |-> !rsp.hit)
		else $error("write-back reported on a hit");

	// hits never outnumber accesses
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.hit_count <= rsp.access_count))
		else $error("hit count exceeds access count");

endmodule
`default_nettype wire
